### hw/rtl/aips_pkg.sv
package aips_pkg;

   localparam int COST_W = 6;
   localparam int CHAR_W = 8;
   localparam int MASK_W = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 64;
   localparam int OFS_W = 16;
   localparam int RSP_DATA_W = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_TOLERANCE = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_WAVE,
      ST_DECIDE
   } state_type;

   function automatic logic [MASK_W-1:0] base_mask(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] c;
      logic [MASK_W-1:0] m;
      c = ch;
      if (c >= 8'd97 && c <= 8'd122) begin
         c = c - 8'd32;
      end
      case (c)
         "A": m = 4'd1;
         "C": m = 4'd2;
         "G": m = 4'd4;
         "T", "U": m = 4'd8;
         "R": m = 4'd5;
         "Y": m = 4'd10;
         "S": m = 4'd6;
         "W": m = 4'd9;
         "K": m = 4'd12;
         "M": m = 4'd3;
         "B": m = 4'd14;
         "D": m = 4'd13;
         "H": m = 4'd11;
         "V": m = 4'd7;
         "N": m = 4'd15;
         default: m = 4'd0;
      endcase
      return m;
   endfunction

endpackage

### hw/rtl/approximate_iupac_primer_search.sv
// Streams a DNA read one ASCII IUPAC base per item and reports, for every base, whether an
// approximate match of the configured primer (up to MAX_PATTERN IUPAC masks) ends there,
// with its start offset, end offset and edit distance; hits never overlap and the last hit
// of a read is its answer. Each item passes through an accept step, a launch step, the column
// update rippling down the chain of row cells one row at a time, and a decision step that
// waits until the output register is free; the next item is taken once the result has
// been moved into the output register. The chain is ready right after reset.
module approximate_iupac_primer_search #(
   parameter int MAX_PATTERN = 32,
   parameter int POS_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // base_char [7:0]
   input  logic [aips_pkg::CHAR_W-1:0]       req_tdata,
   // first_of_read [0]
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // hit_start [15:0], hit_end [31:16], hit_errors [37:32], zero [39:38]
   output logic [aips_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // hit [0]
   output logic [0:0]                        rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [aips_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [aips_pkg::CSR_DATA_W-1:0]   csr_data
);
   import aips_pkg::*;

   localparam int LK_W = (MAX_PATTERN > 0) ? $clog2(MAX_PATTERN + 1) : 1;

   state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0] low_ff, low_in, high_ff, high_in;
   logic [COST_W-1:0]     len_ff, len_in, tol_ff, tol_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in, next_ff, next_in, row0_start_ff, row0_start_in;
   logic [MASK_W-1:0]     bmask_ff, bmask_in;
   logic [COST_W-1:0]     cap_cost_ff, cap_cost_in;
   logic [POS_BITS-1:0]   cap_start_ff, cap_start_in;
   logic                  rsp_valid_ff, rsp_valid_in, rsp_hit_ff, rsp_hit_in;
   logic [OFS_W-1:0]      rsp_start_ff, rsp_start_in, rsp_end_ff, rsp_end_in;
   logic [COST_W-1:0]     rsp_err_ff, rsp_err_in;

   logic                  lk_valid [0:MAX_PATTERN];
   logic [COST_W-1:0]     lk_old_cost [0:MAX_PATTERN];
   logic [POS_BITS-1:0]   lk_old_start [0:MAX_PATTERN];
   logic [COST_W-1:0]     lk_new_cost [0:MAX_PATTERN];
   logic [POS_BITS-1:0]   lk_new_start [0:MAX_PATTERN];

   logic                  accept, launch, decide, fire, hit, restart;
   logic [POS_BITS-1:0]   restart_start, pos_eff;
   logic [COST_W-1:0]     len_eff;

   assign accept = req_tvalid && req_tready;
   assign fire = !rsp_valid_ff || rsp_tready;
   assign hit = cap_cost_ff <= tol_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      len_eff = len_ff;
      if (len_ff == '0) begin
         len_eff = COST_W'(1);
      end else if (len_ff > COST_W'(MAX_PATTERN)) begin
         len_eff = COST_W'(MAX_PATTERN);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: state_in = ST_WAVE;
         ST_WAVE: begin
            if (lk_valid[MAX_PATTERN]) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      launch = 1'b0;
      decide = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_LAUNCH: launch = 1'b1;
         ST_WAVE: ;
         ST_DECIDE: decide = fire;
         default: ;
      endcase
   end

   always_comb begin
      restart = 1'b0;
      restart_start = next_ff;
      if (accept && req_tuser[0]) begin
         restart = 1'b1;
         restart_start = '0;
      end else if (decide && hit) begin
         restart = 1'b1;
      end
   end

   always_comb begin
      low_in = low_ff;
      high_in = high_ff;
      len_in = len_ff;
      tol_in = tol_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_LOW: low_in = csr_data;
            CSR_PATTERN_HIGH: high_in = csr_data;
            CSR_PATTERN_LENGTH: len_in = csr_data[COST_W-1:0];
            CSR_ERROR_TOLERANCE: tol_in = csr_data[COST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pos_eff = req_tuser[0] ? '0 : pos_ff;
      pos_in = pos_ff;
      next_in = next_ff;
      bmask_in = bmask_ff;
      row0_start_in = row0_start_ff;
      if (accept) begin
         next_in = (pos_eff == '1) ? pos_eff : pos_eff + 1'b1;
         pos_in = next_in;
         bmask_in = base_mask(req_tdata);
         if (req_tuser[0]) begin
            row0_start_in = '0;
         end
      end else if (decide) begin
         row0_start_in = next_ff;
      end
   end

   always_comb begin
      cap_cost_in = cap_cost_ff;
      cap_start_in = cap_start_ff;
      if (lk_valid[len_eff[LK_W-1:0]]) begin
         cap_cost_in = lk_new_cost[len_eff[LK_W-1:0]];
         cap_start_in = lk_new_start[len_eff[LK_W-1:0]];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in = rsp_hit_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in = rsp_end_ff;
      rsp_err_in = rsp_err_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (decide) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in = hit;
         rsp_start_in = hit ? OFS_W'(cap_start_ff) : '0;
         rsp_end_in = hit ? OFS_W'(next_ff) : '0;
         rsp_err_in = hit ? cap_cost_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         low_ff <= '0;
         high_ff <= '0;
         len_ff <= COST_W'(1);
         tol_ff <= '0;
         pos_ff <= '0;
         row0_start_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         low_ff <= low_in;
         high_ff <= high_in;
         len_ff <= len_in;
         tol_ff <= tol_in;
         pos_ff <= pos_in;
         row0_start_ff <= row0_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      next_ff <= next_in;
      bmask_ff <= bmask_in;
      cap_cost_ff <= cap_cost_in;
      cap_start_ff <= cap_start_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff <= rsp_end_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign lk_valid[0] = launch;
   assign lk_old_cost[0] = '0;
   assign lk_old_start[0] = row0_start_ff;
   assign lk_new_cost[0] = '0;
   assign lk_new_start[0] = next_ff;

   for (genvar i = 1; i <= MAX_PATTERN; i++) begin : g_cell
      logic [MASK_W-1:0] sym;
      if (i <= 16) begin : g_low
         assign sym = low_ff[MASK_W*(i-1) +: MASK_W];
      end else begin : g_high
         assign sym = high_ff[MASK_W*(i-17) +: MASK_W];
      end
      aips_cell #(
         .ROW(i),
         .POS_BITS(POS_BITS)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .restart(restart),
         .restart_start(restart_start),
         .sym_mask(sym),
         .base_mask(bmask_ff),
         .in_valid(lk_valid[i-1]),
         .in_old_cost(lk_old_cost[i-1]),
         .in_old_start(lk_old_start[i-1]),
         .in_new_cost(lk_new_cost[i-1]),
         .in_new_start(lk_new_start[i-1]),
         .out_valid(lk_valid[i]),
         .out_old_cost(lk_old_cost[i]),
         .out_old_start(lk_old_start[i]),
         .out_new_cost(lk_new_cost[i]),
         .out_new_start(lk_new_start[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_hit_ff;
   assign rsp_tdata = {2'b00, rsp_err_ff, rsp_end_ff, rsp_start_ff};

endmodule

### hw/rtl/aips_cell.sv
module aips_cell #(
   parameter int ROW = 1,
   parameter int POS_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           restart,
   input  logic [POS_BITS-1:0]            restart_start,
   input  logic [aips_pkg::MASK_W-1:0]    sym_mask,
   input  logic [aips_pkg::MASK_W-1:0]    base_mask,
   input  logic                           in_valid,
   input  logic [aips_pkg::COST_W-1:0]    in_old_cost,
   input  logic [POS_BITS-1:0]            in_old_start,
   input  logic [aips_pkg::COST_W-1:0]    in_new_cost,
   input  logic [POS_BITS-1:0]            in_new_start,
   output logic                           out_valid,
   output logic [aips_pkg::COST_W-1:0]    out_old_cost,
   output logic [POS_BITS-1:0]            out_old_start,
   output logic [aips_pkg::COST_W-1:0]    out_new_cost,
   output logic [POS_BITS-1:0]            out_new_start
);
   import aips_pkg::*;

   logic [COST_W-1:0]   cost_ff, cost_in;
   logic [POS_BITS-1:0] start_ff, start_in;
   logic                valid_ff, valid_in;
   logic [COST_W-1:0]   old_cost_ff, old_cost_in;
   logic [POS_BITS-1:0] old_start_ff, old_start_in;
   logic [COST_W-1:0]   new_cost_ff, new_cost_in;
   logic [POS_BITS-1:0] new_start_ff, new_start_in;

   logic [COST_W:0]     diag_cost, up_cost, left_cost, best1_cost, best2_cost;
   logic [POS_BITS-1:0] best1_start, best2_start;

   always_comb begin
      diag_cost = {1'b0, in_old_cost} + {{COST_W{1'b0}}, ((sym_mask & base_mask) == '0)};
      up_cost = {1'b0, cost_ff} + 1'b1;
      left_cost = {1'b0, in_new_cost} + 1'b1;
      best1_cost = diag_cost;
      best1_start = in_old_start;
      if (up_cost < diag_cost || (up_cost == diag_cost && start_ff > in_old_start)) begin
         best1_cost = up_cost;
         best1_start = start_ff;
      end
      best2_cost = best1_cost;
      best2_start = best1_start;
      if (left_cost < best1_cost || (left_cost == best1_cost && in_new_start > best1_start)) begin
         best2_cost = left_cost;
         best2_start = in_new_start;
      end
   end

   always_comb begin
      cost_in = cost_ff;
      start_in = start_ff;
      valid_in = 1'b0;
      old_cost_in = old_cost_ff;
      old_start_in = old_start_ff;
      new_cost_in = new_cost_ff;
      new_start_in = new_start_ff;
      if (restart) begin
         cost_in = COST_W'(ROW);
         start_in = restart_start;
      end else if (in_valid) begin
         cost_in = best2_cost[COST_W-1:0];
         start_in = best2_start;
         valid_in = 1'b1;
         old_cost_in = cost_ff;
         old_start_in = start_ff;
         new_cost_in = best2_cost[COST_W-1:0];
         new_start_in = best2_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cost_ff <= COST_W'(ROW);
         start_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         cost_ff <= cost_in;
         start_ff <= start_in;
         valid_ff <= valid_in;
      end
      old_cost_ff <= old_cost_in;
      old_start_ff <= old_start_in;
      new_cost_ff <= new_cost_in;
      new_start_ff <= new_start_in;
   end

   assign out_valid = valid_ff;
   assign out_old_cost = old_cost_ff;
   assign out_old_start = old_start_ff;
   assign out_new_cost = new_cost_ff;
   assign out_new_start = new_start_ff;

endmodule

### tb/approximate_iupac_primer_search_tb.sv
module approximate_iupac_primer_search_tb;
   import aips_pkg::*;

   localparam int ROWS = 33;
   localparam int LAST_ROW = 32;
   localparam int LATENCY = 40;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 1050;
   localparam int PHASES = 6;
   localparam logic [31:0] PLAIN_BASES = "ACGT";
   localparam logic [95:0] CODE_BASES = "RYSWKMBDHVNU";

   typedef struct packed {
      logic hit;
      logic [OFS_W-1:0] hit_start;
      logic [OFS_W-1:0] hit_end;
      logic [COST_W-1:0] hit_errors;
   } hit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [CHAR_W-1:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic [63:0] primer_lo;
   logic [63:0] primer_hi;
   logic [5:0] primer_len;
   logic [5:0] max_errors;
   int unsigned row_cost[ROWS];
   logic [OFS_W-1:0] row_start[ROWS];
   logic [OFS_W-1:0] read_pos;

   hit_type pending_hits[$];
   int failures = 0;
   int items_sent = 0;
   int cycle_count = 0;
   bit steady = 1'b0;

   approximate_iupac_primer_search uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 33);
   end

   function automatic logic [3:0] iupac_bits(input logic [7:0] ch);
      logic [7:0] u;
      u = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
      case (u)
         "A": return 4'b0001;
         "C": return 4'b0010;
         "G": return 4'b0100;
         "T", "U": return 4'b1000;
         "R": return 4'b0101;
         "Y": return 4'b1010;
         "S": return 4'b0110;
         "W": return 4'b1001;
         "K": return 4'b1100;
         "M": return 4'b0011;
         "B": return 4'b1110;
         "D": return 4'b1101;
         "H": return 4'b1011;
         "V": return 4'b0111;
         "N": return 4'b1111;
         default: return 4'b0000;
      endcase
   endfunction

   function automatic logic [3:0] primer_symbol(input int idx);
      return (idx < 16) ? primer_lo[4*idx +: 4] : primer_hi[4*(idx-16) +: 4];
   endfunction

   function automatic void restart_rows(input logic [OFS_W-1:0] origin);
      for (int r = 0; r < ROWS; r++) begin
         row_cost[r] = r;
         row_start[r] = origin;
      end
   endfunction

   function automatic int rows_in_use();
      if (primer_len == 0) return 1;
      if (primer_len > LAST_ROW) return LAST_ROW;
      return primer_len;
   endfunction

   function automatic hit_type predict_match(input logic [7:0] ch, input bit first);
      int unsigned new_cost[ROWS];
      logic [OFS_W-1:0] new_start[ROWS];
      int unsigned c_diag, c_up, c_left;
      logic [OFS_W-1:0] s_diag, s_up, s_left, after;
      logic [3:0] bm;
      int m;
      hit_type res;
      bm = iupac_bits(ch);
      if (first) begin
         restart_rows('0);
         read_pos = '0;
      end
      after = (read_pos == '1) ? read_pos : read_pos + 1'b1;
      m = rows_in_use();
      new_cost[0] = 0;
      new_start[0] = after;
      for (int r = 1; r < ROWS; r++) begin
         c_diag = row_cost[r-1] + (((primer_symbol(r-1) & bm) != 0) ? 0 : 1);
         s_diag = row_start[r-1];
         c_up = row_cost[r] + 1;
         s_up = row_start[r];
         c_left = new_cost[r-1] + 1;
         s_left = new_start[r-1];
         if (c_up < c_diag || (c_up == c_diag && s_up > s_diag)) begin
            c_diag = c_up;
            s_diag = s_up;
         end
         if (c_left < c_diag || (c_left == c_diag && s_left > s_diag)) begin
            c_diag = c_left;
            s_diag = s_left;
         end
         new_cost[r] = c_diag;
         new_start[r] = s_diag;
      end
      read_pos = after;
      res = '0;
      if (new_cost[m] <= max_errors) begin
         res.hit = 1'b1;
         res.hit_start = new_start[m];
         res.hit_end = after;
         res.hit_errors = COST_W'(new_cost[m]);
         restart_rows(after);
      end else begin
         row_cost = new_cost;
         row_start = new_start;
      end
      return res;
   endfunction

   always @(posedge clock) begin : check_rsp
      hit_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_hits.size() == 0) begin
            $error("rsp item arrived with no expected result pending");
            failures++;
         end else begin
            want = pending_hits.pop_front();
            if (rsp_tuser[0] !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_tuser[0]);
               failures++;
            end
            if (rsp_tdata[15:0] !== want.hit_start) begin
               $error("hit_start: expected %0d, got %0d", want.hit_start, rsp_tdata[15:0]);
               failures++;
            end
            if (rsp_tdata[31:16] !== want.hit_end) begin
               $error("hit_end: expected %0d, got %0d", want.hit_end, rsp_tdata[31:16]);
               failures++;
            end
            if (rsp_tdata[37:32] !== want.hit_errors) begin
               $error("hit_errors: expected %0d, got %0d", want.hit_errors, rsp_tdata[37:32]);
               failures++;
            end
         end
      end
   end

   task automatic send_base(input logic [7:0] ch, input bit first);
      if (!steady) begin
         while ($urandom_range(99) < 33) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      req_tuser <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_hits = {pending_hits, predict_match(ch, first)};
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_hits.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_PATTERN_LOW: primer_lo = value;
         CSR_PATTERN_HIGH: primer_hi = value;
         CSR_PATTERN_LENGTH: primer_len = value[5:0];
         CSR_ERROR_TOLERANCE: max_errors = value[5:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [63:0] len, input logic [63:0] tol);
      wait_idle();
      write_reg(CSR_PATTERN_LOW, lo);
      write_reg(CSR_PATTERN_HIGH, hi);
      write_reg(CSR_PATTERN_LENGTH, len);
      write_reg(CSR_ERROR_TOLERANCE, tol);
      csr_valid <= 1'b0;
   endtask

   task automatic send_text(input logic [8*16-1:0] text, input int count, input bit first);
      for (int i = count - 1; i >= 0; i--) begin
         send_base(text[8*i +: 8], first && (i == count - 1));
      end
   endtask

   function automatic logic [7:0] flank_base();
      logic [7:0] c;
      int pick;
      pick = $urandom_range(99);
      if (pick >= 95) return 8'($urandom_range(255));
      if (pick < 85) c = PLAIN_BASES[8*$urandom_range(3) +: 8];
      else c = CODE_BASES[8*$urandom_range(11) +: 8];
      if ($urandom_range(3) == 0) c = c | 8'h20;
      return c;
   endfunction

   function automatic logic [7:0] base_for_mask(input logic [3:0] m);
      logic [7:0] c;
      int k;
      if (m == 4'b0000) return flank_base();
      do k = $urandom_range(3); while (!m[k]);
      c = PLAIN_BASES[8*(3-k) +: 8];
      if (k == 3 && $urandom_range(4) == 0) c = "U";
      if ($urandom_range(3) == 0) c = c | 8'h20;
      return c;
   endfunction

   function automatic logic [63:0] random_masks();
      logic [63:0] v;
      int p;
      for (int s = 0; s < 16; s++) begin
         p = $urandom_range(99);
         if (p < 65) v[4*s +: 4] = 4'b0001 << $urandom_range(3);
         else if (p < 95) v[4*s +: 4] = 4'($urandom_range(15, 1));
         else v[4*s +: 4] = 4'b0000;
      end
      return v;
   endfunction

   // A read is mostly flanking bases around mutated copies of the primer; a few are pure
   // noise, and a few carry no first-of-read flag or a stray one in the middle.
   task automatic send_read();
      logic [7:0] bases[$];
      int kind, m, copies;
      logic [3:0] sm;
      kind = $urandom_range(99);
      m = rows_in_use();
      if (kind < 10) begin
         repeat ($urandom_range(20, 1)) bases = {bases, 8'($urandom_range(255))};
      end else begin
         repeat ($urandom_range(10)) bases = {bases, flank_base()};
         copies = ($urandom_range(3) == 0) ? $urandom_range(2) : 1;
         repeat (copies) begin
            for (int j = 0; j < m; j++) begin
               sm = primer_symbol(j);
               case ($urandom_range(39))
                  0: bases = {bases, flank_base()};
                  1: ;
                  2: begin
                     bases = {bases, flank_base()};
                     bases = {bases, base_for_mask(sm)};
                  end
                  default: bases = {bases, base_for_mask(sm)};
               endcase
            end
            repeat ($urandom_range(6)) bases = {bases, flank_base()};
         end
      end
      for (int i = 0; i < bases.size(); i++) begin
         send_base(bases[i], (i == 0 && kind < 95) || (i > 0 && $urandom_range(199) == 0));
      end
   endtask

   task automatic test_reset_defaults();
      send_base("A", 1'b1);
      send_base(8'hFF, 1'b0);
   endtask

   task automatic test_exact_primer();
      configure(64'h8421, '1, 4, 0);
      send_text("ACGT", 4, 1'b1);
   endtask

   task automatic test_iupac_codes();
      configure(64'h8421, '1, 4, 1);
      send_text("rYsWkMbDhVnu", 12, 1'b1);
      send_base(8'h00, 1'b0);
      send_base(8'hFF, 1'b0);
      send_base("{", 1'b0);
   endtask

   task automatic test_length_limits();
      configure(64'h1, 64'h0, 0, 0);
      send_text("AC", 2, 1'b1);
      configure(64'h0, 64'h0, '1, '1);
      send_text("GT", 2, 1'b1);
   endtask

   task automatic test_tolerance_at_length();
      configure(random_masks(), random_masks(), 8, 8);
      send_text("CA", 2, 1'b1);
   endtask

   task automatic test_length_change_mid_read();
      configure(64'h8421, 64'h0, 4, 1);
      send_text("AC", 2, 1'b1);
      configure(64'h8421, 64'h0, 2, 1);
      send_text("GT", 2, 1'b0);
   endtask

   task automatic test_random_reads();
      int goal;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: configure(random_masks(), random_masks(), 32, 0);
            1: configure(random_masks(), random_masks(), 1, 0);
            2: configure(random_masks(), random_masks(), $urandom_range(12, 4), $urandom_range(2));
            3: configure(random_masks(), random_masks(), $urandom_range(24, 12),
                         $urandom_range(4, 1));
            4: configure(random_masks(), random_masks(), 32, 32);
            default: configure(random_masks(), random_masks(), {$urandom, $urandom},
                               $urandom_range(8));
         endcase
         steady = (phase == 3);
         goal = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < goal) send_read();
      end
      steady = 1'b0;
   endtask

   initial begin
      primer_lo = '0;
      primer_hi = '0;
      primer_len = 6'd1;
      max_errors = '0;
      restart_rows('0);
      read_pos = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_exact_primer();
      test_iupac_codes();
      test_length_limits();
      test_tolerance_at_length();
      test_length_change_mid_read();
      test_random_reads();
      wait_idle();
      repeat (LATENCY) @(posedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
